/* rtl/charge_current_limit_stepper_core_assert.svh */
// Assertion macros for the charge current limit stepper checker.
// Self-contained; expects a clock and a synchronous active-high reset.
`ifndef CHARGE_CURRENT_LIMIT_STEPPER_CORE_ASSERT_SVH
`define CHARGE_CURRENT_LIMIT_STEPPER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CCLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccls check failed");

// Next-cycle implication.
`define CCLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccls check failed");

`endif

/* rtl/ccls_pkg.sv */
// Shared types, constants and helpers for the charge current limit stepper.
// No dependencies.
`default_nettype none

package ccls_pkg;

   localparam int unsigned TEMP_W     = 11;
   localparam int unsigned MV_W       = 13;
   localparam int unsigned DELTA_W    = 10;
   localparam int unsigned MARGIN_W   = 9;
   localparam int unsigned STEP_W     = 10;
   localparam int unsigned LIMIT_W    = 11;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [LIMIT_W-1:0] MA_LOW   = 11'd100;
   localparam logic [LIMIT_W-1:0] MA_MID   = 11'd400;
   localparam logic [LIMIT_W-1:0] MA_HIGH  = 11'd800;
   localparam logic [LIMIT_W-1:0] MA_STAND = 11'd1800;
   localparam logic [LIMIT_W-1:0] MA_CEIL  = 11'd1800;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_PAD    = 2'd1;
   localparam logic [1:0] KIND_STAND  = 2'd2;
   localparam logic [1:0] KIND_FORCED = 2'd3;

   localparam logic [1:0] CODE_LOW  = 2'd0;
   localparam logic [1:0] CODE_MID  = 2'd1;
   localparam logic [1:0] CODE_HIGH = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_LOW_TO_MID      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_MID_TO_HIGH_MIN = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_MID_TO_HIGH_MAX = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_MID_TO_LOW      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_HIGH_COOL       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_TEMP_HIGH_WARM       = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_FULL_MARGIN_MV       = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_MA              = 3'd7;

   typedef enum logic [2:0] {
      LEVEL_LOW  = 3'b001,
      LEVEL_MID  = 3'b010,
      LEVEL_HIGH = 3'b100
   } level_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_low_to_mid;
      logic signed [TEMP_W-1:0] temp_mid_to_high_min;
      logic signed [TEMP_W-1:0] temp_mid_to_high_max;
      logic signed [TEMP_W-1:0] temp_mid_to_low;
      logic signed [TEMP_W-1:0] temp_high_cool;
      logic signed [TEMP_W-1:0] temp_high_warm;
      logic [MARGIN_W-1:0]      full_margin_mv;
      logic [STEP_W-1:0]        step_ma;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               connect_kind;
      logic signed [TEMP_W-1:0] battery_temp;
      logic [MV_W-1:0]          battery_mv;
      logic [MV_W-1:0]          full_mv;
      logic [DELTA_W-1:0]       recharge_gap_mv;
   } beat_type;

   function automatic logic [1:0] level_code(level_type lvl);
      logic [1:0] code;
      case (lvl)
         LEVEL_LOW:  code = CODE_LOW;
         LEVEL_HIGH: code = CODE_HIGH;
         default:    code = CODE_MID;
      endcase
      return code;
   endfunction

   function automatic logic [LIMIT_W-1:0] level_ma(level_type lvl);
      logic [LIMIT_W-1:0] ma;
      case (lvl)
         LEVEL_LOW:  ma = MA_LOW;
         LEVEL_HIGH: ma = MA_HIGH;
         default:    ma = MA_MID;
      endcase
      return ma;
   endfunction

endpackage

`default_nettype wire

/* rtl/ccls_cfg.sv */
// Configuration register bank for the charge current limit stepper.
// Depends on ccls_pkg.
`default_nettype none

module ccls_cfg
   import ccls_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_TEMP_LOW_TO_MID:      cfg_in.temp_low_to_mid      = csr_wdata;
            REG_TEMP_MID_TO_HIGH_MIN: cfg_in.temp_mid_to_high_min = csr_wdata;
            REG_TEMP_MID_TO_HIGH_MAX: cfg_in.temp_mid_to_high_max = csr_wdata;
            REG_TEMP_MID_TO_LOW:      cfg_in.temp_mid_to_low      = csr_wdata;
            REG_TEMP_HIGH_COOL:       cfg_in.temp_high_cool       = csr_wdata;
            REG_TEMP_HIGH_WARM:       cfg_in.temp_high_warm       = csr_wdata;
            REG_FULL_MARGIN_MV:       cfg_in.full_margin_mv = csr_wdata[MARGIN_W-1:0];
            REG_STEP_MA:              cfg_in.step_ma        = csr_wdata[STEP_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.temp_low_to_mid      <= 11'sd530;
         cfg_ff.temp_mid_to_high_min <= 11'sd40;
         cfg_ff.temp_mid_to_high_max <= 11'sd425;
         cfg_ff.temp_mid_to_low      <= 11'sd550;
         cfg_ff.temp_high_cool       <= 11'sd20;
         cfg_ff.temp_high_warm       <= 11'sd445;
         cfg_ff.full_margin_mv       <= 9'd20;
         cfg_ff.step_ma              <= 10'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/ccls_level.sv */
// Target level next-state logic: temperature and voltage hysteresis on pad, mid otherwise.
// Depends on ccls_pkg.
`default_nettype none

module ccls_level
   import ccls_pkg::*;
(
   input  beat_type  beat,
   input  cfg_type   cfg,
   input  level_type level_cur,
   output level_type level_nxt
);

   logic signed [MV_W+1:0] vbat_s;
   logic signed [MV_W+1:0] resume_floor;
   logic signed [MV_W+1:0] full_floor;
   logic                   go_high;
   logic                   go_low;
   logic                   drop_high;
   logic                   rise_low;

   always_comb begin
      vbat_s       = $signed({2'b00, beat.battery_mv});
      resume_floor = $signed({2'b00, beat.full_mv}) - $signed({5'b00000, beat.recharge_gap_mv});
      full_floor   = $signed({2'b00, beat.full_mv}) - $signed({6'b000000, cfg.full_margin_mv});

      rise_low  = beat.battery_temp < cfg.temp_low_to_mid;
      go_high   = (cfg.temp_mid_to_high_min <= beat.battery_temp)
                  && (beat.battery_temp < cfg.temp_mid_to_high_max)
                  && (vbat_s < resume_floor);
      go_low    = cfg.temp_mid_to_low <= beat.battery_temp;
      drop_high = (beat.battery_temp < cfg.temp_high_cool)
                  || (cfg.temp_high_warm <= beat.battery_temp)
                  || (full_floor <= vbat_s);

      level_nxt = LEVEL_MID;
      if (beat.connect_kind == KIND_PAD) begin
         unique case (level_cur)
            LEVEL_LOW:  level_nxt = rise_low ? LEVEL_MID : LEVEL_LOW;
            LEVEL_MID:  level_nxt = go_high ? LEVEL_HIGH : (go_low ? LEVEL_LOW : LEVEL_MID);
            LEVEL_HIGH: level_nxt = drop_high ? LEVEL_MID : LEVEL_HIGH;
            default:    level_nxt = LEVEL_MID;
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/ccls_limit.sv */
// Applied limit stepper: on pad, one step toward the target, saturated to the
// ceiling; MA_STAND on stand, MA_MID otherwise. Depends on ccls_pkg.
`default_nettype none

module ccls_limit
   import ccls_pkg::*;
(
   input  wire logic [1:0]         connect_kind,
   input  level_type               level_nxt,
   input  wire logic [LIMIT_W-1:0] limit_prev,
   input  wire logic [STEP_W-1:0]  step_ma,
   output logic      [LIMIT_W-1:0] limit_nxt,
   output logic                    limit_changed
);

   logic [LIMIT_W-1:0]       target_ma;
   logic signed [LIMIT_W+1:0] sum;

   always_comb begin
      target_ma = level_ma(level_nxt);
      if (target_ma < limit_prev) begin
         sum = $signed({2'b00, limit_prev}) - $signed({3'b000, step_ma});
      end else if (limit_prev < target_ma) begin
         sum = $signed({2'b00, limit_prev}) + $signed({3'b000, step_ma});
      end else begin
         sum = $signed({2'b00, limit_prev});
      end

      case (connect_kind)
         KIND_PAD: begin
            if (sum < 0) begin
               limit_nxt = '0;
            end else if (sum > $signed({2'b00, MA_CEIL})) begin
               limit_nxt = MA_CEIL;
            end else begin
               limit_nxt = sum[LIMIT_W-1:0];
            end
         end
         KIND_STAND: limit_nxt = MA_STAND;
         default:    limit_nxt = MA_MID;
      endcase

      limit_changed = limit_nxt != limit_prev;
   end

endmodule

`default_nettype wire

/* rtl/charge_current_limit_stepper_core.sv */
// Charge current limit stepper: one result beat per request beat. A request
// is captured in an input register, evaluated combinationally and lands in
// the result register: one beat per cycle unless back-pressure stalls, and a
// result is valid once through both registers. Target level and applied limit
// update as each beat enters the result register, so consecutive beats see
// each other's effect with no gap. rsp_ready back-pressure stalls the input
// register only once both registers hold a beat. The user must write registers
// via csr_we/csr_addr/csr_wdata only while no beat is in flight (not enforced).
// Depends on ccls_pkg, ccls_cfg, ccls_level and ccls_limit.
`default_nettype none

module charge_current_limit_stepper_core
   import ccls_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_connect_kind,
   input  wire logic signed [TEMP_W-1:0] req_battery_temp,
   input  wire logic [MV_W-1:0]       req_battery_mv,
   input  wire logic [MV_W-1:0]       req_full_mv,
   input  wire logic [DELTA_W-1:0]    req_recharge_gap_mv,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [LIMIT_W-1:0]         rsp_limit_ma,
   output logic                       rsp_limit_changed,
   output logic [1:0]                 rsp_target_level,

   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg;
   beat_type           beat_ff, beat_in;
   logic               s1_valid_ff, s1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] rsp_limit_ff, rsp_limit_in;
   logic               rsp_changed_ff, rsp_changed_in;
   logic [1:0]         rsp_level_ff, rsp_level_in;
   level_type          level_ff, level_in;
   logic [LIMIT_W-1:0] applied_ff, applied_in;
   level_type          level_nxt;
   logic [LIMIT_W-1:0] limit_nxt;
   logic               limit_changed;
   logic               advance;
   logic               take;

   ccls_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ccls_level u_level (
      .beat      (beat_ff),
      .cfg       (cfg),
      .level_cur (level_ff),
      .level_nxt (level_nxt)
   );

   ccls_limit u_limit (
      .connect_kind  (beat_ff.connect_kind),
      .level_nxt     (level_nxt),
      .limit_prev    (applied_ff),
      .step_ma       (cfg.step_ma),
      .limit_nxt     (limit_nxt),
      .limit_changed (limit_changed)
   );

   always_comb begin
      advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !s1_valid_ff || advance;
      take      = req_valid && req_ready;

      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
      beat_in     = beat_ff;
      if (take) begin
         beat_in.connect_kind    = req_connect_kind;
         beat_in.battery_temp    = req_battery_temp;
         beat_in.battery_mv      = req_battery_mv;
         beat_in.full_mv         = req_full_mv;
         beat_in.recharge_gap_mv = req_recharge_gap_mv;
      end

      rsp_valid_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_limit_in   = advance ? limit_nxt : rsp_limit_ff;
      rsp_changed_in = advance ? limit_changed : rsp_changed_ff;
      rsp_level_in   = advance ? level_code(level_nxt) : rsp_level_ff;
      level_in       = advance ? level_nxt : level_ff;
      applied_in     = advance ? limit_nxt : applied_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         level_ff     <= LEVEL_MID;
         applied_ff   <= MA_MID;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         level_ff     <= level_in;
         applied_ff   <= applied_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff        <= beat_in;
      rsp_limit_ff   <= rsp_limit_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_level_ff   <= rsp_level_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_limit_ma      = rsp_limit_ff;
   assign rsp_limit_changed = rsp_changed_ff;
   assign rsp_target_level  = rsp_level_ff;

endmodule

`default_nettype wire

/* rtl/ccls_checker.sv */
// Port-level checker for the charge current limit stepper, bound to the top.
// Depends on ccls_pkg and charge_current_limit_stepper_core_assert.svh.
`default_nettype none
`include "charge_current_limit_stepper_core_assert.svh"

module ccls_checker
   import ccls_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic [LIMIT_W-1:0]       rsp_limit_ma,
   input wire logic                     rsp_limit_changed,
   input wire logic [1:0]               rsp_target_level
);

   `CCLS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_limit_ma) && $stable(rsp_limit_changed) && $stable(rsp_target_level))

   `CCLS_ASSERT_NOW(a_limit_ceiling, clock, reset, rsp_valid, rsp_limit_ma <= MA_CEIL)

   `CCLS_ASSERT_NOW(a_level_code, clock, reset, rsp_valid, rsp_target_level == CODE_LOW || rsp_target_level == CODE_MID || rsp_target_level == CODE_HIGH)

   `CCLS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind charge_current_limit_stepper_core ccls_checker u_ccls_checker (.*);

`default_nettype wire
